/* rtl/udpck_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the udp pseudo-header checksum core
// no dependencies

package udpck_pkg;

  // byte position counter width within one packet
  localparam int POS_W = 17;

  // bytes of ipv4 pseudo-header in front of each datagram
  localparam logic [POS_W-1:0] PSEUDO_BYTES = 17'd12;
  // datagram offset of the checksum word, left out of the sum
  localparam logic [POS_W-1:0] SKIP_OFFSET  = 17'd6;
  // position counter saturates here, then alternates with POS_MAX - 1
  localparam logic [POS_W-1:0] POS_MAX      = 17'h1FFFF;

  // one paired word handed from the pairing stage to the accumulator
  typedef struct packed {
    logic        add;   // word takes part in the sum
    logic [15:0] word;  // big-endian pair, zero low byte when padded
    logic        last;  // closes the packet, checksum goes out
  } udpck_word_t;

endpackage

/* rtl/udpck_pairer.sv */
`timescale 1ns / 1ps
// byte pairing stage: tracks packet position, pairs bytes into words,
// marks the skipped checksum word; depends on udpck_pkg

module udpck_pairer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                advance,
  output logic                s1_valid,
  output udpck_pkg::udpck_word_t s1_item
);
  import udpck_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  udpck_word_t      s1_item_r, s1_item_nxt;

  logic             accept;
  logic             in_pseudo;
  logic [POS_W-1:0] off;
  logic             seg_end;
  logic             skip_even;
  logic             skip_odd;

  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  assign in_pseudo = pos_r < PSEUDO_BYTES;
  assign off       = in_pseudo ? pos_r : pos_r - PSEUDO_BYTES;
  assign seg_end   = in_tlast || (in_pseudo && (pos_r == PSEUDO_BYTES - 17'd1));
  assign skip_even = !in_pseudo && (off == SKIP_OFFSET);
  assign skip_odd  = !in_pseudo && ((off - 17'd1) == SKIP_OFFSET);

  always_comb begin
    s1_item_nxt.last = in_tlast;
    held_nxt         = held_r;
    pos_nxt          = pos_r;
    if (off[0] == 1'b0) begin
      // high byte of a word, or a padded odd final byte
      s1_item_nxt.word = {in_tdata, 8'h00};
      s1_item_nxt.add  = seg_end && !skip_even;
      held_nxt         = seg_end ? 8'h00 : in_tdata;
    end else begin
      s1_item_nxt.word = {held_r, in_tdata};
      s1_item_nxt.add  = !skip_odd;
      held_nxt         = 8'h00;
    end
    if (pos_r == POS_MAX) begin
      pos_nxt = POS_MAX - 17'd1;
    end else begin
      pos_nxt = pos_r + 17'd1;
    end
    if (in_tlast) begin
      pos_nxt  = '0;
      held_nxt = 8'h00;
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      held_r     <= 8'h00;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        pos_r  <= pos_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  // a packet boundary leaves the pairing state clear
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> pos_r == '0 && held_r == 8'h00)
    else $error("pairing state not cleared after last byte");

  // a stalled word stays put until the accumulator takes it
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled word changed or dropped");

  // an empty stage always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with an empty stage");

endmodule

/* rtl/udpck_accum.sv */
`timescale 1ns / 1ps
// ones' complement accumulator and checksum output register
// depends on udpck_pkg

module udpck_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  udpck_pkg::udpck_word_t s1_item,
  output logic                advance,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata
);
  import udpck_pkg::*;

  logic [15:0] acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic [16:0] sum17;
  logic [15:0] acc_add;
  logic [15:0] acc_fin;

  // a closing word waits only while the previous checksum is still held
  assign advance = s1_valid && (!s1_item.last || !out_valid_r || out_tready);

  // end-around carry add
  assign sum17   = {1'b0, acc_r} + {1'b0, s1_item.word};
  assign acc_add = sum17[15:0] + {15'd0, sum17[16]};
  assign acc_fin = s1_item.add ? acc_add : acc_r;

  always_comb begin
    acc_nxt      = acc_r;
    out_data_nxt = out_data_r;
    if (advance) begin
      if (s1_item.last) begin
        acc_nxt      = 16'h0000;
        out_data_nxt = ~acc_fin;
      end else begin
        acc_nxt = acc_fin;
      end
    end
  end

  always_comb begin
    if (advance && s1_item.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a checksum shows up only for a closing word
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && s1_item.last))
    else $error("checksum raised without a closing word");

  // the sum restarts from zero after each packet
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_item.last |=> acc_r == 16'h0000)
    else $error("accumulator not cleared after packet");

  // a held checksum is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_item.last && out_valid_r && !out_tready |-> !advance)
    else $error("closing word advanced over a pending checksum");

endmodule

/* rtl/udp_pseudo_header_checksum_core.sv */
`timescale 1ns / 1ps
// top level of the udp checksum core over ipv4 pseudo-header and datagram
// depends on udpck_pkg, udpck_pairer, udpck_accum

// Takes one packet byte per transaction: the 12 pseudo-header bytes first,
// then the udp datagram, in_tlast on the final byte. Bytes are paired
// big-endian into 16-bit words per segment and summed with end-around carry;
// the datagram word at offset 6 (the checksum field) is left out and an odd
// final byte is padded with a zero low byte. For each packet one 16-bit
// checksum (complement of the folded sum, zero not remapped) comes out after
// its last byte passes the pairing register and the output register. A byte
// is taken every cycle: the only loop is the 16-bit end-around add in the
// accumulator, and bytes of the next packet keep flowing while a checksum
// waits on out_tready; only the next closing byte stalls until it is taken.

module udp_pseudo_header_checksum_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] checksum
);
  import udpck_pkg::*;

  // pairing stage to accumulator
  logic        s1_valid;
  udpck_word_t s1_item;
  logic        advance;

  // position tracking, byte pairing, skip of the checksum field
  udpck_pairer u_pairer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  // ones' complement sum and checksum output register
  udpck_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
